@@ hdl/pbs_pkg.sv @@
package pbs_pkg;

  // Default queue size
  localparam int QUEUE_DEPTH_DEF = 16;

  // Field widths
  localparam int ID_W   = 8;
  localparam int DUR_W  = 8;
  localparam int PRI_W  = 4;
  localparam int TIME_W = 12;
  localparam int STAT_W = 2;
  localparam int JOB_W  = ID_W + DUR_W + PRI_W;  // 20-bit stored job

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_ADDED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_JOB   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

  // Input operation codes
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_RUN = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic              add_wr;       // append incoming job
    logic              run_init;     // start of a run
    logic              scan_en;      // walk the store one entry a cycle
    logic              emit_resp;    // load a single-word response
    logic [STAT_W-1:0] resp_status;
    logic              emit_job;     // dispatch the selected job
  } pbs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic scan_done;
    logic last_job;
    logic out_free;
  } pbs_sts_t;

endpackage

@@ hdl/priority_batch_scheduler_core.sv @@
// Priority batch scheduler. Each input word either appends a job (id, duration,
// priority) to a queue of QUEUE_DEPTH entries, answered by one word with status
// added or full, or starts a run, which dispatches every queued job in descending
// priority, ties in arrival order, each with its start tick (saturating sum of
// the earlier durations) and tlast on the final one; a run on an empty queue
// gives one empty-status word. In a run of n jobs each dispatch rescans all n
// store entries through the single registered read port of the job RAM, one entry
// a cycle; then the last read lands, the scan closes and the output register is
// loaded, which waits while the output is held off. A new input word is taken
// once the previous one is fully dispatched into the output register; no clearing
// pass is needed after reset.
module priority_batch_scheduler_core #(
  parameter int QUEUE_DEPTH = pbs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // job_id[7:0], job_duration[15:8], job_priority[19:16]
  input  logic [0:0]  in_tuser,   // operation[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_id[7:0], start_time[19:8], out_duration[27:20],
                                  // out_priority[31:28]
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast
);

  import pbs_pkg::*;

  pbs_cmd_t          cmd;
  pbs_sts_t          sts;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   out_id;
  logic [TIME_W-1:0] start_time;
  logic [DUR_W-1:0]  out_duration;
  logic [PRI_W-1:0]  out_priority;

  pbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .operation (in_tuser[0]),
    .sts       (sts),
    .cmd       (cmd)
  );

  pbs_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .job_id       (in_tdata[7:0]),
    .job_duration (in_tdata[15:8]),
    .job_priority (in_tdata[19:16]),
    .out_vld      (out_tvalid),
    .out_rdy      (out_tready),
    .out_status   (status),
    .out_id       (out_id),
    .out_start    (start_time),
    .out_dur      (out_duration),
    .out_pri      (out_priority),
    .out_last     (out_tlast)
  );

  assign out_tdata = {out_priority, out_duration, start_time, out_id};
  assign out_tuser = status;

endmodule

@@ hdl/pbs_ram.sv @@
module pbs_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/pbs_ctrl.sv @@
module pbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              operation,
  input  pbs_pkg::pbs_sts_t sts,
  output pbs_pkg::pbs_cmd_t cmd
);

  import pbs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RESP = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_PICK = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [STAT_W-1:0] resp_r, resp_nxt;
  logic              acc;

  assign in_tready = (state_r == ST_IDLE);
  assign acc       = in_tvalid && in_tready;

  // Next state and commands
  always_comb begin
    state_nxt       = state_r;
    resp_nxt        = resp_r;
    cmd             = '0;
    cmd.resp_status = resp_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (operation == OP_ADD) begin
            cmd.add_wr = !sts.full;
            resp_nxt   = sts.full ? STAT_FULL : STAT_ADDED;
            state_nxt  = ST_RESP;
          end else if (sts.empty) begin
            resp_nxt  = STAT_EMPTY;
            state_nxt = ST_RESP;
          end else begin
            cmd.run_init = 1'b1;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.emit_resp = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        if (sts.out_free) begin
          cmd.emit_job = 1'b1;
          state_nxt    = sts.last_job ? ST_IDLE : ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      resp_r  <= STAT_ADDED;
    end else begin
      state_r <= state_nxt;
      resp_r  <= resp_nxt;
    end
  end

`ifndef ASSERT_OFF
  // A run is only started with jobs queued
  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run_init |-> !sts.empty)
    else $error("run started on empty queue");

  // A pick only follows a finished scan
  a_pick_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && sts.scan_done |=> state_r == ST_PICK)
    else $error("finished scan did not lead to a pick");

  // No add is written into a full queue
  a_no_full_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add_wr |-> !sts.full)
    else $error("write into full queue");
`endif

endmodule

@@ hdl/pbs_datapath.sv @@
module pbs_datapath #(
  parameter int QUEUE_DEPTH = pbs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pbs_pkg::pbs_cmd_t          cmd,
  output pbs_pkg::pbs_sts_t          sts,
  input  logic [pbs_pkg::ID_W-1:0]   job_id,
  input  logic [pbs_pkg::DUR_W-1:0]  job_duration,
  input  logic [pbs_pkg::PRI_W-1:0]  job_priority,
  output logic                       out_vld,
  input  logic                       out_rdy,
  output logic [pbs_pkg::STAT_W-1:0] out_status,
  output logic [pbs_pkg::ID_W-1:0]   out_id,
  output logic [pbs_pkg::TIME_W-1:0] out_start,
  output logic [pbs_pkg::DUR_W-1:0]  out_dur,
  output logic [pbs_pkg::PRI_W-1:0]  out_pri,
  output logic                       out_last
);

  import pbs_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       rem_r, rem_nxt;
  logic [CNT_W-1:0]       scan_r, scan_nxt;
  logic [TIME_W-1:0]      elapsed_r, elapsed_nxt;
  logic [QUEUE_DEPTH-1:0] taken_r, taken_nxt;
  logic                   rd_vld_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic                   best_vld_r, best_vld_nxt;
  logic [IDX_W-1:0]       best_idx_r, best_idx_nxt;
  logic [JOB_W-1:0]       best_job_r, best_job_nxt;
  logic [JOB_W-1:0]       rd_job;
  logic                   rd_en;
  logic                   better;
  logic [TIME_W:0]        time_sum;
  logic                   out_vld_r;
  logic [STAT_W-1:0]      out_status_r;
  logic [ID_W-1:0]        out_id_r;
  logic [TIME_W-1:0]      out_start_r;
  logic [DUR_W-1:0]       out_dur_r;
  logic [PRI_W-1:0]       out_pri_r;
  logic                   out_last_r;

  // Job store: id, duration, priority from the top bits down
  pbs_ram #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.add_wr),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data ({job_id, job_duration, job_priority}),
    .rd_en   (rd_en),
    .rd_addr (scan_r[IDX_W-1:0]),
    .rd_data (rd_job)
  );

  assign rd_en = cmd.scan_en && (scan_r != count_r);

  // Strictly greater keeps the earliest of equal priorities
  assign better = rd_vld_r && !taken_r[rd_idx_r] &&
                  (!best_vld_r || (rd_job[PRI_W-1:0] > best_job_r[PRI_W-1:0]));

  assign time_sum = {1'b0, elapsed_r} + {{(TIME_W + 1 - DUR_W){1'b0}},
                                         best_job_r[PRI_W +: DUR_W]};

  // Status to controller
  assign sts.full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign sts.empty     = (count_r == '0);
  assign sts.scan_done = (scan_r == count_r) && !rd_vld_r;
  assign sts.last_job  = (rem_r == CNT_W'(1));
  assign sts.out_free  = !out_vld_r || out_rdy;

  // Queue, scan and selection state
  always_comb begin
    count_nxt    = count_r;
    rem_nxt      = rem_r;
    scan_nxt     = scan_r;
    elapsed_nxt  = elapsed_r;
    taken_nxt    = taken_r;
    best_vld_nxt = best_vld_r;
    best_idx_nxt = best_idx_r;
    best_job_nxt = best_job_r;
    if (cmd.add_wr) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.run_init) begin
      rem_nxt      = count_r;
      scan_nxt     = '0;
      elapsed_nxt  = '0;
      best_vld_nxt = 1'b0;
    end
    if (rd_en) begin
      scan_nxt = scan_r + CNT_W'(1);
    end
    if (better) begin
      best_vld_nxt = 1'b1;
      best_idx_nxt = rd_idx_r;
      best_job_nxt = rd_job;
    end
    if (cmd.emit_job) begin
      rem_nxt               = rem_r - CNT_W'(1);
      scan_nxt              = '0;
      best_vld_nxt          = 1'b0;
      taken_nxt[best_idx_r] = 1'b1;
      elapsed_nxt           = time_sum[TIME_W] ? {TIME_W{1'b1}} : time_sum[TIME_W-1:0];
      if (sts.last_job) begin
        count_nxt = '0;
        taken_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      rem_r      <= '0;
      scan_r     <= '0;
      elapsed_r  <= '0;
      taken_r    <= '0;
      rd_vld_r   <= 1'b0;
      best_vld_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      rem_r      <= rem_nxt;
      scan_r     <= scan_nxt;
      elapsed_r  <= elapsed_nxt;
      taken_r    <= taken_nxt;
      rd_vld_r   <= rd_en;
      best_vld_r <= best_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= scan_r[IDX_W-1:0];
    best_idx_r <= best_idx_nxt;
    best_job_r <= best_job_nxt;
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.emit_resp || cmd.emit_job) begin
      out_vld_r <= 1'b1;
    end else if (out_rdy) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_job) begin
      out_status_r <= STAT_JOB;
      out_id_r     <= best_job_r[JOB_W-1 -: ID_W];
      out_start_r  <= elapsed_r;
      out_dur_r    <= best_job_r[PRI_W +: DUR_W];
      out_pri_r    <= best_job_r[PRI_W-1:0];
      out_last_r   <= sts.last_job;
    end else if (cmd.emit_resp) begin
      out_status_r <= cmd.resp_status;
      out_id_r     <= '0;
      out_start_r  <= '0;
      out_dur_r    <= '0;
      out_pri_r    <= '0;
      out_last_r   <= 1'b1;
    end
  end

  assign out_vld    = out_vld_r;
  assign out_status = out_status_r;
  assign out_id     = out_id_r;
  assign out_start  = out_start_r;
  assign out_dur    = out_dur_r;
  assign out_pri    = out_pri_r;
  assign out_last   = out_last_r;

`ifndef ASSERT_OFF
  // Every dispatch has a selected job
  a_pick_has_best: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_job |-> best_vld_r)
    else $error("dispatch without a selected job");

  // The final dispatch leaves the queue empty and all marks clear
  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_job && sts.last_job |=> (count_r == '0) && (taken_r == '0))
    else $error("queue not cleared after run");

  // A run starts from zero time with every queued job outstanding
  a_run_init: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run_init |=> (elapsed_r == '0) && (rem_r == $past(count_r)))
    else $error("run not initialised");

  // Jobs outstanding never exceed jobs queued
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= count_r)
    else $error("outstanding count exceeds queue count");
`endif

endmodule
